FILE: rtl/core/jsu_pkg.sv
// Package for the JSON string unescaper: parser phases, status codes and the
// records that pass between the front end, the group queue and the output stage.
// No dependencies.
`default_nettype none

package jsu_pkg;

    // Default number of decoded groups held between front end and output stage.
    localparam int unsigned QueueDepth = 4;

    // Characters of interest in the raw text.
    localparam logic [7:0] ChQuote  = 8'h22;
    localparam logic [7:0] ChBslash = 8'h5C;
    localparam logic [7:0] ChLowerU = 8'h75;
    localparam logic [7:0] ChSpace  = 8'h20;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_BODY,
        PH_ESC,
        PH_HEX1,
        PH_NEEDBS,
        PH_NEEDU,
        PH_HEX2
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK,
        ST_CLOSED,
        ST_NOQUOTE,
        ST_CTRL,
        ST_BADESC,
        ST_BADHEX,
        ST_UNPAIR,
        ST_EARLY
    } t_status;

    // All results caused by one input byte.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            has_byte;
        t_status         status;
    } t_grp;

    // One result as it leaves the block.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last_of_run;
        t_status    status;
    } t_item;

endpackage

`default_nettype wire

FILE: rtl/core/jsu_if.sv
// Valid/ready channel interfaces for the raw input bytes and the decoded results.
// No dependencies.
`default_nettype none

interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_marker;

    modport source (output valid, output in_byte, output end_marker, input ready);
    modport sink   (input valid, input in_byte, input end_marker, output ready);
endinterface

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last_of_run;
    logic [2:0] status;

    modport source (output valid, output out_byte, output byte_valid,
                    output last_of_run, output status, input ready);
    modport sink   (input valid, input out_byte, input byte_valid,
                    input last_of_run, input status, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/jsu_front.sv
// Front end: parses one raw byte per transfer and turns it into a group of up to
// four UTF-8 bytes plus a status. Depends on jsu_pkg.
`default_nettype none

module jsu_front
    import jsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_end,
    output logic       o_ready,
    input  logic       i_push_ready,
    output logic       o_push,
    output t_grp       o_grp
);

    t_phase      r_phase, n_phase;
    logic [11:0] r_accum, n_accum;
    logic [1:0]  r_digits, n_digits;
    logic [9:0]  r_high, n_high;

    logic        take;
    logic        hex_ok;
    logic [3:0]  hex_nib;
    logic [15:0] hex_v;
    logic        is_hi;
    logic        is_lo;
    logic        esc_ok;
    logic [7:0]  esc_byte;
    logic [20:0] cp_pair;
    logic [20:0] cp_sel;
    t_grp        enc;

    function automatic t_grp encode_utf8(input logic [20:0] cp);
        t_grp g;
        g          = '0;
        g.has_byte = 1'b1;
        g.status   = ST_OK;
        if (cp <= 21'h7F) begin
            g.bytes[0] = cp[7:0];
            g.last_idx = 2'd0;
        end else if (cp <= 21'h7FF) begin
            g.bytes[0] = 8'hC0 | {3'b000, cp[10:6]};
            g.bytes[1] = 8'h80 | {2'b00, cp[5:0]};
            g.last_idx = 2'd1;
        end else if (cp <= 21'hFFFF) begin
            g.bytes[0] = 8'hE0 | {4'b0000, cp[15:12]};
            g.bytes[1] = 8'h80 | {2'b00, cp[11:6]};
            g.bytes[2] = 8'h80 | {2'b00, cp[5:0]};
            g.last_idx = 2'd2;
        end else begin
            g.bytes[0] = 8'hF0 | {5'b00000, cp[20:18]};
            g.bytes[1] = 8'h80 | {2'b00, cp[17:12]};
            g.bytes[2] = 8'h80 | {2'b00, cp[11:6]};
            g.bytes[3] = 8'h80 | {2'b00, cp[5:0]};
            g.last_idx = 2'd3;
        end
        return g;
    endfunction

    assign o_ready = i_push_ready;
    assign take    = i_valid && i_push_ready;
    assign o_push  = take;

    // Hex digit recognition and the value once this digit is appended.
    always_comb begin
        hex_ok  = 1'b0;
        hex_nib = 4'd0;
        if (i_byte >= 8'h30 && i_byte <= 8'h39) begin
            hex_ok  = 1'b1;
            hex_nib = i_byte[3:0];
        end else if ((i_byte >= 8'h61 && i_byte <= 8'h66) ||
                     (i_byte >= 8'h41 && i_byte <= 8'h46)) begin
            hex_ok  = 1'b1;
            hex_nib = i_byte[3:0] + 4'd9;
        end
    end

    assign hex_v   = {r_accum, hex_nib};
    assign is_hi   = (hex_v[15:10] == 6'b110110);
    assign is_lo   = (hex_v[15:10] == 6'b110111);
    assign cp_pair = 21'h10000 + {1'b0, r_high, hex_v[9:0]};
    assign cp_sel  = (r_phase == PH_HEX2) ? cp_pair : {5'd0, hex_v};
    assign enc     = encode_utf8(cp_sel);

    // Simple escapes; the u escape is handled separately.
    always_comb begin
        esc_ok   = 1'b1;
        esc_byte = 8'h00;
        case (i_byte)
            8'h22:   esc_byte = 8'h22;
            8'h5C:   esc_byte = 8'h5C;
            8'h2F:   esc_byte = 8'h2F;
            8'h62:   esc_byte = 8'h08;
            8'h66:   esc_byte = 8'h0C;
            8'h6E:   esc_byte = 8'h0A;
            8'h72:   esc_byte = 8'h0D;
            8'h74:   esc_byte = 8'h09;
            default: esc_ok   = 1'b0;
        endcase
    end

    // Next state.
    always_comb begin
        logic clr;
        clr      = 1'b0;
        n_phase  = r_phase;
        n_accum  = r_accum;
        n_digits = r_digits;
        n_high   = r_high;
        if (take) begin
            if (i_end) begin
                clr = 1'b1;
            end else begin
                unique case (r_phase)
                    PH_IDLE: begin
                        if (i_byte == ChQuote) n_phase = PH_BODY;
                    end
                    PH_BODY: begin
                        if (i_byte == ChQuote || i_byte < ChSpace) clr = 1'b1;
                        else if (i_byte == ChBslash) n_phase = PH_ESC;
                    end
                    PH_ESC: begin
                        if (esc_ok) begin
                            n_phase = PH_BODY;
                        end else if (i_byte == ChLowerU) begin
                            n_phase  = PH_HEX1;
                            n_accum  = '0;
                            n_digits = '0;
                        end else begin
                            clr = 1'b1;
                        end
                    end
                    PH_HEX1, PH_HEX2: begin
                        if (!hex_ok) begin
                            clr = 1'b1;
                        end else if (r_digits != 2'd3) begin
                            n_accum  = hex_v[11:0];
                            n_digits = r_digits + 2'd1;
                        end else if (r_phase == PH_HEX1) begin
                            n_accum  = '0;
                            n_digits = '0;
                            if (is_hi) begin
                                n_high  = hex_v[9:0];
                                n_phase = PH_NEEDBS;
                            end else if (is_lo) begin
                                clr = 1'b1;
                            end else begin
                                n_phase = PH_BODY;
                            end
                        end else begin
                            if (is_lo) begin
                                n_accum  = '0;
                                n_digits = '0;
                                n_high   = '0;
                                n_phase  = PH_BODY;
                            end else begin
                                clr = 1'b1;
                            end
                        end
                    end
                    PH_NEEDBS: begin
                        if (i_byte == ChBslash) n_phase = PH_NEEDU;
                        else clr = 1'b1;
                    end
                    PH_NEEDU: begin
                        if (i_byte == ChLowerU) begin
                            n_phase  = PH_HEX2;
                            n_accum  = '0;
                            n_digits = '0;
                        end else begin
                            clr = 1'b1;
                        end
                    end
                    default: clr = 1'b1;
                endcase
            end
        end
        if (clr) begin
            n_phase  = PH_IDLE;
            n_accum  = '0;
            n_digits = '0;
            n_high   = '0;
        end
    end

    // Group of results for the byte on the input.
    always_comb begin
        o_grp        = '0;
        o_grp.status = ST_OK;
        if (i_end) begin
            o_grp.status = ST_EARLY;
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_byte != ChQuote) o_grp.status = ST_NOQUOTE;
                end
                PH_BODY: begin
                    if (i_byte == ChQuote) begin
                        o_grp.status = ST_CLOSED;
                    end else if (i_byte == ChBslash) begin
                        o_grp.status = ST_OK;
                    end else if (i_byte < ChSpace) begin
                        o_grp.status = ST_CTRL;
                    end else begin
                        o_grp.bytes[0] = i_byte;
                        o_grp.has_byte = 1'b1;
                    end
                end
                PH_ESC: begin
                    if (esc_ok) begin
                        o_grp.bytes[0] = esc_byte;
                        o_grp.has_byte = 1'b1;
                    end else if (i_byte != ChLowerU) begin
                        o_grp.status = ST_BADESC;
                    end
                end
                PH_HEX1, PH_HEX2: begin
                    if (!hex_ok) begin
                        o_grp.status = ST_BADHEX;
                    end else if (r_digits == 2'd3) begin
                        if (r_phase == PH_HEX1) begin
                            if (is_lo) o_grp.status = ST_UNPAIR;
                            else if (!is_hi) o_grp = enc;
                        end else begin
                            if (is_lo) o_grp = enc;
                            else o_grp.status = ST_UNPAIR;
                        end
                    end
                end
                PH_NEEDBS: begin
                    if (i_byte != ChBslash) o_grp.status = ST_UNPAIR;
                end
                PH_NEEDU: begin
                    if (i_byte != ChLowerU) o_grp.status = ST_UNPAIR;
                end
                default: o_grp.status = ST_OK;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_accum  <= '0;
            r_digits <= '0;
            r_high   <= '0;
        end else begin
            r_phase  <= n_phase;
            r_accum  <= n_accum;
            r_digits <= n_digits;
            r_high   <= n_high;
        end
    end

`ifndef SYNTHESIS
    a_err_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && o_grp.status != ST_OK |=> r_phase == PH_IDLE)
        else $error("front end not back in idle after a closing or error status");
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE |-> r_accum == '0 && r_digits == '0 && r_high == '0)
        else $error("escape state left behind in idle");
    a_digits_only_in_hex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_HEX1 && r_phase != PH_HEX2 |-> r_digits == '0)
        else $error("hex digit count set outside a hex escape");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/jsu_grp_queue.sv
// Short first-in first-out queue of result groups between the front end and the
// output stage. Depends on jsu_pkg.
`default_nettype none

module jsu_grp_queue
    import jsu_pkg::*;
#(
    parameter int unsigned DEPTH = QueueDepth
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_grp i_grp,
    output logic o_ready,
    input  logic i_pop,
    output logic o_avail,
    output t_grp o_head
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);

    t_grp            r_mem [DEPTH];
    logic [PtrW-1:0] r_wr, n_wr;
    logic [PtrW-1:0] r_rd, n_rd;
    logic [CntW-1:0] r_count, n_count;

    assign o_ready = (r_count != CntW'(DEPTH));
    assign o_avail = (r_count != '0);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) n_wr = (r_wr == PtrW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        if (i_pop)  n_rd = (r_rd == PtrW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        if (i_push && !i_pop) n_count = r_count + 1'b1;
        else if (!i_push && i_pop) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_grp;
    end

endmodule

`default_nettype wire

FILE: rtl/core/jsu_back.sv
// Output stage: walks the head group byte by byte into a registered output item.
// Depends on jsu_pkg.
`default_nettype none

module jsu_back
    import jsu_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_avail,
    input  t_grp  i_grp,
    output logic  o_pop,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);

    logic       r_valid, n_valid;
    logic [1:0] r_idx, n_idx;
    t_item      r_item, n_item;
    logic       load;
    logic       emit;
    logic       at_last;

    assign load    = !r_valid || i_ready;
    assign emit    = load && i_avail;
    assign at_last = (r_idx == i_grp.last_idx);
    assign o_pop   = emit && at_last;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_valid = load ? i_avail : r_valid;
        n_idx   = r_idx;
        n_item  = r_item;
        if (emit) begin
            n_item.out_byte    = i_grp.bytes[r_idx];
            n_item.byte_valid  = i_grp.has_byte;
            n_item.last_of_run = at_last;
            n_item.status      = i_grp.status;
            n_idx              = at_last ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

`ifndef SYNTHESIS
    a_pop_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> i_avail)
        else $error("group released from an empty queue");
    a_idx_in_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_avail |-> r_idx <= i_grp.last_idx)
        else $error("byte index runs past the end of the head group");
    a_inner_has_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_item.last_of_run |-> r_item.byte_valid)
        else $error("non-final result without a decoded byte");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/json_string_unescape_utf8.sv
// Top level of the streaming JSON string unescaper with UTF-8 output.
// Depends on jsu_pkg, jsu_if, jsu_front, jsu_grp_queue and jsu_back.
//
// Usage: raw JSON text enters on i_in one byte per transfer, starting with the
// opening quote; end_marker set in a transfer signals end of input. Every input
// transfer causes one to four result transfers on o_out. A byte that decodes
// to nothing gives one result with byte_valid low; last_of_run marks the final
// result of each input byte, and all results of one byte carry the same status.
// After a closing quote or any error the decoder waits for a new opening quote.
// The first result of an input byte is offered once its group is in the queue
// and its first byte in the output register. Throughput: one input byte per
// cycle while each byte decodes to at most one result and o_out is ready; the
// output stage sends one result per cycle while o_out is ready, so a byte that
// decodes to several bytes holds it until all are sent, and the group queue
// absorbs such bursts. i_in.ready falls only when the queue of QDEPTH groups is
// full, which happens when the receiver stalls o_out or a run of multi-byte
// escapes outpaces the output. Synchronous active-low reset empties the queue
// and the output register and returns the parser to waiting.
`default_nettype none

module json_string_unescape_utf8
    import jsu_pkg::*;
#(
    parameter int unsigned QDEPTH = QueueDepth
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    jsu_in_if.sink     i_in,
    jsu_out_if.source  o_out
);

    // Front end to queue.
    logic  q_ready;
    logic  push;
    t_grp  push_grp;

    // Queue to output stage.
    logic  q_avail;
    logic  pop;
    t_grp  head_grp;

    t_item out_item;

    // The front end classifies the byte and builds its whole result group in
    // the cycle of the transfer; it stalls only on a full queue.
    jsu_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in.valid),
        .i_byte       (i_in.in_byte),
        .i_end        (i_in.end_marker),
        .o_ready      (i_in.ready),
        .i_push_ready (q_ready),
        .o_push       (push),
        .o_grp        (push_grp)
    );

    jsu_grp_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_grp   (push_grp),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_avail (q_avail),
        .o_head  (head_grp)
    );

    // The output stage releases a group once its last byte is registered.
    jsu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (q_avail),
        .i_grp   (head_grp),
        .o_pop   (pop),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_item  (out_item)
    );

    assign o_out.out_byte    = out_item.out_byte;
    assign o_out.byte_valid  = out_item.byte_valid;
    assign o_out.last_of_run = out_item.last_of_run;
    assign o_out.status      = 3'(out_item.status);

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking testbench for json_string_unescape_utf8: drives raw JSON text bytes
// and checks every decoded result against a cycle-free predictor of the decoder.
// Depends on jsu_pkg, jsu_in_if, jsu_out_if and the json_string_unescape_utf8 RTL.

module tb_top;
    import jsu_pkg::*;

    // Surrogate ranges of UTF-16, as they appear in a \uXXXX escape.
    localparam logic [15:0] HiSurFirst = 16'hD800;
    localparam logic [15:0] HiSurLast  = 16'hDBFF;
    localparam logic [15:0] LoSurFirst = 16'hDC00;
    localparam logic [15:0] LoSurLast  = 16'hDFFF;

    // Kinds of malformed string that the random stimulus can end with.
    typedef enum int {
        FLT_CTRL,       // raw control byte inside the string
        FLT_ESC,        // backslash followed by an unknown letter
        FLT_HEX,        // non-hex character inside \uXXXX
        FLT_HI_NOBS,    // high surrogate followed by anything but a backslash
        FLT_HI_NOU,     // high surrogate, backslash, then anything but u
        FLT_HI_NOLO,    // high surrogate followed by \u that is not a low surrogate
        FLT_LONE_LO,    // low surrogate with no high surrogate before it
        FLT_END,        // input ends in the middle of the string
        FLT_HEX2        // non-hex character in the escape after a high surrogate
    } t_fault;

    // One input transfer as queued for the driver.
    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } t_raw;

    logic clk;
    logic rst_n;

    jsu_in_if  in_ch ();
    jsu_out_if out_ch ();

    json_string_unescape_utf8 dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Raw bytes still to be offered, and the decoded results still to arrive.
    t_raw  text_q [$];
    t_item decoded_q [$];

    // Predictor state: a private copy of the parser registers.
    t_phase      ph      = PH_IDLE;
    logic [15:0] hex_val = '0;
    logic [1:0]  hex_cnt = '0;
    logic [9:0]  hi_surr = '0;

    int unsigned n_errors  = 0;
    int unsigned n_fed     = 0;
    int unsigned n_results = 0;
    int unsigned n_closed  = 0;
    int unsigned n_faults  = 0;
    int unsigned n_quad    = 0;

    // Idling control for both sides. A calm stretch draws no new gaps.
    int unsigned in_gap   = 0;
    int unsigned in_calm  = 0;
    int unsigned out_hold = 0;
    int unsigned out_calm = 0;
    int unsigned gap_draw;
    logic        squeeze  = 1'b0;
    t_raw        cur;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        return -1;
    endfunction

    // Splits a code point into its UTF-8 bytes and returns how many there are.
    function automatic int to_utf8(input logic [20:0] cp, output logic [3:0][7:0] ob);
        ob = '0;
        if (cp <= 21'h7F) begin
            ob[0] = cp[7:0];
            return 1;
        end
        if (cp <= 21'h7FF) begin
            ob[0] = {3'b110, cp[10:6]};
            ob[1] = {2'b10, cp[5:0]};
            return 2;
        end
        if (cp <= 21'hFFFF) begin
            ob[0] = {4'b1110, cp[15:12]};
            ob[1] = {2'b10, cp[11:6]};
            ob[2] = {2'b10, cp[5:0]};
            return 3;
        end
        ob[0] = {5'b11110, cp[20:18]};
        ob[1] = {2'b10, cp[17:12]};
        ob[2] = {2'b10, cp[11:6]};
        ob[3] = {2'b10, cp[5:0]};
        return 4;
    endfunction

    function automatic void go_idle();
        ph      = PH_IDLE;
        hex_val = '0;
        hex_cnt = '0;
        hi_surr = '0;
    endfunction

    // Advances the parser copy by one accepted input transfer and queues the
    // results that the block must produce for it.
    function automatic void decode_byte(input logic [7:0] c, input logic fin);
        logic [3:0][7:0] ob;
        logic [15:0]     v;
        logic [20:0]     cp;
        t_status         st;
        t_item           r;
        int              n;
        int              h;
        int              i;
        ob = '0;
        n  = 0;
        st = ST_OK;
        if (fin) begin
            go_idle();
            st = ST_EARLY;
        end else begin
            case (ph)
                PH_IDLE: begin
                    if (c == ChQuote) ph = PH_BODY;
                    else st = ST_NOQUOTE;
                end
                PH_BODY: begin
                    if (c == ChQuote) begin
                        go_idle();
                        st = ST_CLOSED;
                    end else if (c == ChBslash) begin
                        ph = PH_ESC;
                    end else if (c < ChSpace) begin
                        go_idle();
                        st = ST_CTRL;
                    end else begin
                        ob[0] = c;
                        n = 1;
                    end
                end
                PH_ESC: begin
                    ph = PH_BODY;
                    n = 1;
                    case (c)
                        "\"": ob[0] = 8'h22;
                        "\\": ob[0] = 8'h5C;
                        "/":  ob[0] = 8'h2F;
                        "b":  ob[0] = 8'h08;
                        "f":  ob[0] = 8'h0C;
                        "n":  ob[0] = 8'h0A;
                        "r":  ob[0] = 8'h0D;
                        "t":  ob[0] = 8'h09;
                        ChLowerU: begin
                            n = 0;
                            ph = PH_HEX1;
                            hex_val = '0;
                            hex_cnt = '0;
                        end
                        default: begin
                            n = 0;
                            go_idle();
                            st = ST_BADESC;
                        end
                    endcase
                end
                PH_HEX1, PH_HEX2: begin
                    h = hex_nibble(c);
                    if (h < 0) begin
                        go_idle();
                        st = ST_BADHEX;
                    end else begin
                        v = {hex_val[11:0], h[3:0]};
                        if (hex_cnt != 2'd3) begin
                            hex_val = v;
                            hex_cnt = hex_cnt + 2'd1;
                        end else if (ph == PH_HEX1) begin
                            hex_val = '0;
                            hex_cnt = '0;
                            if (v >= HiSurFirst && v <= HiSurLast) begin
                                hi_surr = v[9:0];
                                ph = PH_NEEDBS;
                            end else if (v >= LoSurFirst && v <= LoSurLast) begin
                                go_idle();
                                st = ST_UNPAIR;
                            end else begin
                                ph = PH_BODY;
                                n = to_utf8({5'd0, v}, ob);
                            end
                        end else if (v < LoSurFirst || v > LoSurLast) begin
                            go_idle();
                            st = ST_UNPAIR;
                        end else begin
                            // The pair covers the planes above the BMP.
                            cp = 21'h10000 + {1'b0, hi_surr, v[9:0]};
                            go_idle();
                            ph = PH_BODY;
                            n = to_utf8(cp, ob);
                        end
                    end
                end
                PH_NEEDBS: begin
                    if (c == ChBslash) begin
                        ph = PH_NEEDU;
                    end else begin
                        go_idle();
                        st = ST_UNPAIR;
                    end
                end
                PH_NEEDU: begin
                    if (c == ChLowerU) begin
                        ph = PH_HEX2;
                        hex_val = '0;
                        hex_cnt = '0;
                    end else begin
                        go_idle();
                        st = ST_UNPAIR;
                    end
                end
                default: begin
                    go_idle();
                    st = ST_OK;
                end
            endcase
        end

        if (st == ST_CLOSED) n_closed++;
        if (st >= ST_NOQUOTE) n_faults++;
        if (n == 4) n_quad++;

        if (n == 0) begin
            r.out_byte    = '0;
            r.byte_valid  = 1'b0;
            r.last_of_run = 1'b1;
            r.status      = st;
            decoded_q.insert(decoded_q.size(), r);
        end else begin
            for (i = 0; i < n; i++) begin
                r.out_byte    = ob[i];
                r.byte_valid  = 1'b1;
                r.last_of_run = (i == n - 1);
                r.status      = st;
                decoded_q.insert(decoded_q.size(), r);
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------

    task automatic put_item(input logic [7:0] b, input logic fin);
        t_raw r;
        r.ch  = b;
        r.fin = fin;
        text_q.insert(text_q.size(), r);
    endtask

    task automatic put_byte(input logic [7:0] b);
        put_item(b, 1'b0);
    endtask

    // The byte under an end marker is ignored by the block, so it is random.
    task automatic put_end();
        put_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic put_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) put_byte(s[i]);
    endtask

    // Hex letters come in either case at random.
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) return "0" + {4'h0, nib};
        if ($urandom_range(0, 1) == 0) return "A" + {4'h0, nib} - 8'd10;
        return "a" + {4'h0, nib} - 8'd10;
    endfunction

    task automatic put_hex_digits(input logic [15:0] v, input int count);
        int i;
        for (i = 3; i > 3 - count; i--) put_byte(hex_char(v[i*4 +: 4]));
    endtask

    task automatic put_uesc(input logic [15:0] v);
        put_byte(ChBslash);
        put_byte(ChLowerU);
        put_hex_digits(v, 4);
    endtask

    function automatic logic is_esc_letter(input logic [7:0] c);
        return c == "\"" || c == "\\" || c == "/" || c == "b" || c == "f" ||
               c == "n" || c == "r" || c == "t" || c == ChLowerU;
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(32, 255));
        while (b == ChQuote || b == ChBslash);
        return b;
    endfunction

    function automatic logic [7:0] non_hex_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (hex_nibble(b) >= 0);
        return b;
    endfunction

    // A code point of the BMP outside the surrogate block, with the edges of
    // the one-, two- and three-byte classes drawn now and then.
    function automatic logic [15:0] bmp_value();
        logic [15:0] v;
        case ($urandom_range(0, 3))
            0: v = 16'($urandom_range(0, 16'h7F));
            1: v = 16'($urandom_range(16'h80, 16'h7FF));
            2: begin
                do v = 16'($urandom_range(16'h800, 16'hFFFF));
                while (v >= HiSurFirst && v <= LoSurLast);
            end
            default: begin
                case ($urandom_range(0, 7))
                    0: v = 16'h0000;
                    1: v = 16'h007F;
                    2: v = 16'h0080;
                    3: v = 16'h07FF;
                    4: v = 16'h0800;
                    5: v = 16'hD7FF;
                    6: v = 16'hE000;
                    default: v = 16'hFFFF;
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic put_segment();
        case ($urandom_range(0, 5))
            0, 1: put_byte(plain_byte());
            2: begin
                put_byte(ChBslash);
                case ($urandom_range(0, 7))
                    0: put_byte("\"");
                    1: put_byte("\\");
                    2: put_byte("/");
                    3: put_byte("b");
                    4: put_byte("f");
                    5: put_byte("n");
                    6: put_byte("r");
                    default: put_byte("t");
                endcase
            end
            3, 4: put_uesc(bmp_value());
            default: begin
                put_uesc(16'($urandom_range(HiSurFirst, HiSurLast)));
                put_uesc(16'($urandom_range(LoSurFirst, LoSurLast)));
            end
        endcase
    endtask

    task automatic put_fault();
        t_fault f;
        logic [7:0]  b;
        logic [15:0] v;
        f = t_fault'($urandom_range(FLT_CTRL, FLT_HEX2));
        case (f)
            FLT_CTRL: put_byte(8'($urandom_range(0, 8'h1F)));
            FLT_ESC: begin
                put_byte(ChBslash);
                do b = 8'($urandom_range(0, 255));
                while (is_esc_letter(b));
                put_byte(b);
            end
            FLT_HEX, FLT_HEX2: begin
                if (f == FLT_HEX2) begin
                    put_uesc(16'($urandom_range(HiSurFirst, HiSurLast)));
                end
                put_byte(ChBslash);
                put_byte(ChLowerU);
                put_hex_digits(16'($urandom_range(0, 16'hFFFF)), $urandom_range(0, 3));
                put_byte(non_hex_byte());
            end
            FLT_HI_NOBS: begin
                put_uesc(16'($urandom_range(HiSurFirst, HiSurLast)));
                do b = 8'($urandom_range(0, 255));
                while (b == ChBslash);
                put_byte(b);
            end
            FLT_HI_NOU: begin
                put_uesc(16'($urandom_range(HiSurFirst, HiSurLast)));
                put_byte(ChBslash);
                do b = 8'($urandom_range(0, 255));
                while (b == ChLowerU);
                put_byte(b);
            end
            FLT_HI_NOLO: begin
                put_uesc(16'($urandom_range(HiSurFirst, HiSurLast)));
                do v = 16'($urandom_range(0, 16'hFFFF));
                while (v >= LoSurFirst && v <= LoSurLast);
                put_uesc(v);
            end
            FLT_LONE_LO: put_uesc(16'($urandom_range(LoSurFirst, LoSurLast)));
            default: put_end();
        endcase
    endtask

    // Mostly well-formed strings with random content; a fifth of them break
    // off with a fault, and some are preceded by stray bytes or an end marker.
    task automatic put_string();
        int k;
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                do k = $urandom_range(0, 255);
                while (k == ChQuote);
                put_byte(8'(k));
            end
        end
        if ($urandom_range(0, 11) == 0) put_end();
        put_byte(ChQuote);
        repeat ($urandom_range(0, 6)) put_segment();
        if ($urandom_range(0, 4) == 0) put_fault();
        else put_byte(ChQuote);
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        n_errors++;
    endtask

    // Compares one result transfer with the oldest expectation, field by field.
    task automatic check_result();
        t_item want;
        n_results++;
        if (decoded_q.size() == 0) begin
            report($sformatf("result %0d arrived with nothing expected (byte 0x%02h)",
                             n_results, out_ch.out_byte));
            return;
        end
        want = decoded_q.pop_front();
        if (out_ch.out_byte !== want.out_byte)
            report($sformatf("result %0d out_byte 0x%02h, expected 0x%02h",
                             n_results, out_ch.out_byte, want.out_byte));
        if (out_ch.byte_valid !== want.byte_valid)
            report($sformatf("result %0d byte_valid %b, expected %b",
                             n_results, out_ch.byte_valid, want.byte_valid));
        if (out_ch.last_of_run !== want.last_of_run)
            report($sformatf("result %0d last_of_run %b, expected %b",
                             n_results, out_ch.last_of_run, want.last_of_run));
        if (out_ch.status !== want.status)
            report($sformatf("result %0d status %0d, expected %s",
                             n_results, out_ch.status, want.status.name()));
    endtask

    // Mostly no gap, then short ones, and now and again a long one.
    function automatic int unsigned draw_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 2);
        if (r < 97) return $urandom_range(3, 8);
        return $urandom_range(12, 30);
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers queued bytes, holding each until it is transferred.
    // The prediction is made at the edge of the transfer, from the values
    // that were on the channel just before it.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (in_ch.valid) begin
                decode_byte(in_ch.in_byte, in_ch.end_marker);
                n_fed++;
            end
            if (in_gap != 0) begin
                in_gap--;
                in_ch.valid <= 1'b0;
            end else if (text_q.size() != 0) begin
                cur = text_q.pop_front();
                in_ch.valid      <= 1'b1;
                in_ch.in_byte    <= cur.ch;
                in_ch.end_marker <= cur.fin;
                if (in_calm != 0) begin
                    in_calm--;
                    in_gap = 0;
                end else begin
                    in_gap = draw_gap();
                    if ($urandom_range(0, 39) == 0) in_calm = $urandom_range(20, 80);
                end
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each result transfer and throttles ready. While the
    // squeeze is on, ready stays low so that the group queue fills and the
    // block has to stall its input.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) check_result();
            if (squeeze) begin
                out_ch.ready <= 1'b0;
            end else if (out_hold != 0) begin
                out_hold--;
                out_ch.ready <= 1'b0;
            end else if (out_calm != 0) begin
                out_calm--;
                out_ch.ready <= 1'b1;
            end else begin
                gap_draw = draw_gap();
                if ($urandom_range(0, 39) == 0) out_calm = $urandom_range(20, 80);
                if (gap_draw == 0) begin
                    out_ch.ready <= 1'b1;
                end else begin
                    out_ch.ready <= 1'b0;
                    out_hold = gap_draw - 1;
                end
            end
        end
    end

    // One long hold-off of the receiver, well into the random traffic. The
    // sender carries on offering bytes throughout it.
    initial begin
        wait (n_fed >= 120);
        @(posedge clk);
        squeeze <= 1'b1;
        repeat (80) @(posedge clk);
        squeeze <= 1'b0;
    end

    // Hard limit on the run, far beyond the slowest correct one.
    initial begin
        #5000000;
        $display("json_string_unescape_utf8 verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus, reset and end of test.
    // ------------------------------------------------------------------
    initial begin
        int unsigned n_directed;
        rst_n             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.in_byte     = '0;
        in_ch.end_marker  = 1'b0;
        out_ch.ready      = 1'b0;

        // Directed opening: a stray byte and an end marker while waiting, a
        // string with the top byte, the solidus escape and the highest
        // surrogate pair, then a control byte, a bad escape and an early end.
        put_byte("x");
        put_end();
        put_byte(ChQuote);
        put_byte(8'hFF);
        put_text("\\/");
        put_text("\\uDBFF\\udfff");
        put_byte(ChQuote);
        put_byte(ChQuote);
        put_byte(8'h00);
        put_text("\"\\q");
        put_byte(ChQuote);
        put_end();
        n_directed = text_q.size();

        while (text_q.size() < n_directed + 400) put_string();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Sampled at the falling edge, when every process of the rising edge
        // has settled.
        do @(negedge clk);
        while (text_q.size() != 0 || in_ch.valid || decoded_q.size() != 0);

        // Watch for stray results once all expected ones have arrived.
        repeat (8) @(posedge clk);

        $display("Fed %0d bytes: %0d strings closed, %0d faults flagged.",
                 n_fed, n_closed, n_faults);
        $display("Checked %0d results, %0d of them surrogate pairs decoded to four bytes.",
                 n_results, n_quad);
        if (n_errors == 0) begin
            $display("json_string_unescape_utf8 verification clean");
        end else begin
            $display("json_string_unescape_utf8 verification failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/jsu_pkg.sv
rtl/core/jsu_if.sv
rtl/core/jsu_front.sv
rtl/core/jsu_grp_queue.sv
rtl/core/jsu_back.sv
rtl/core/json_string_unescape_utf8.sv
dv/tb_top.sv
